// ----- rtl/tcw_pkg.sv -----
// Package for the text console writer.
// Types, codes and fixed widths shared by the interfaces, the RAM user and the top level.
// No dependencies.
package tcw_pkg;

  localparam int ROW_CNT_W = 8;
  localparam int COL_CNT_W = 9;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [7:0] RESET_COLUMNS = 8'd80;
  localparam logic [6:0] RESET_ROWS    = 7'd25;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] character;
    logic [5:0] read_row;
    logic [6:0] read_column;
  } cmd_t;

  typedef struct packed {
    logic [5:0] cursor_row_out;
    logic [7:0] cursor_column_out;
    logic [7:0] read_char;
    logic       read_valid;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_NEWLINE,
    ST_COPY,
    ST_DECIDE,
    ST_BLANK,
    ST_FINISH
  } state_t;

endpackage

// ----- rtl/tcw_if.sv -----
// Valid/ready channel interfaces for the text console writer.
// Depends on tcw_pkg for the payload types.
interface tcw_cmd_if import tcw_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/text_console_writer.sv -----
// Text console writer top level: cursor, scroll sequencer and screen RAM.
// Depends on tcw_pkg, tcw_cmd_if, tcw_rsp_if and tcw_ram.
//
//   port    dir  kind         content
//   cmd     in   valid/ready  cmd_t: operation, character, read_row, read_column
//   rsp     out  valid/ready  rsp_t: cursor row/column, read_char, read_valid
//   cfg_*   in   write only   cfg_index 0 = columns, 1 = rows
//
// Read or plain put: accept in idle, then execute. Newline/wrap without scroll: accept,
// execute, newline, finish. Each scroll pass copies rows 1 to rows-1 up by one row, then
// decides; the last pass of a line advance blanks the bottom row. One RAM port each way.
// After reset a clear pass writes all 2^(row bits + column bits) cells (8192 by
// default) with spaces; cmd.ready stays low during it.
// A transaction is accepted only in idle; a waiting result stalls the execute step.
module text_console_writer import tcw_pkg::*; #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  logic        clk,
  input  logic        rst,
  tcw_cmd_if.sink     cmd,
  tcw_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int COL_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW     = COL_AW + ROW_AW;
  localparam int DEPTH  = 2 ** AW;

  state_t state, state_next;

  logic [7:0]           columns;
  logic [6:0]           rows;
  cmd_t                 item;
  logic [ROW_CNT_W-1:0] cur_row, cur_row_next;
  logic [COL_CNT_W-1:0] cur_col, cur_col_next;
  logic [ROW_CNT_W-1:0] scan_row, scan_row_next;
  logic [COL_CNT_W-1:0] scan_col, scan_col_next;
  logic [AW-1:0]        clr_addr;
  logic                 cp_wr_valid, cp_wr_valid_next;
  logic [AW-1:0]        cp_wr_addr, cp_wr_addr_next;
  logic                 rsp_valid, rsp_valid_next;
  rsp_t                 rsp_data, rsp_data_next;

  logic [COL_CNT_W-1:0] nc;
  logic [ROW_CNT_W-1:0] nr;
  logic                 is_put, ordinary, need_nl, out_free;
  logic [ROW_CNT_W-1:0] row_inc, row_dec, scan_row_m1, cmd_row, item_row;
  logic [COL_CNT_W-1:0] cmd_col, item_col;
  logic                 copy_last, blank_last;
  logic                 rd_ok;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [7:0]           ram_wdata, ram_rdata;

  assign nc = (columns == 8'd0) ? COL_CNT_W'(1) :
              (COL_CNT_W'(columns) > COL_CNT_W'(MAX_COLUMNS)) ? COL_CNT_W'(MAX_COLUMNS) :
              COL_CNT_W'(columns);
  assign nr = (rows == 7'd0) ? ROW_CNT_W'(1) :
              (ROW_CNT_W'(rows) > ROW_CNT_W'(MAX_ROWS)) ? ROW_CNT_W'(MAX_ROWS) :
              ROW_CNT_W'(rows);

  assign is_put      = (item.operation == OP_PUT);
  assign ordinary    = (item.character != CH_NEWLINE) && (item.character != CH_RETURN);
  assign need_nl     = is_put && ((item.character == CH_NEWLINE) ||
                                  (ordinary && (cur_col >= nc)));
  assign out_free    = !rsp_valid || rsp.ready;
  assign row_inc     = cur_row + ROW_CNT_W'(1);
  assign row_dec     = cur_row - ROW_CNT_W'(1);
  assign scan_row_m1 = scan_row - ROW_CNT_W'(1);
  assign copy_last   = (scan_row == nr - ROW_CNT_W'(1)) && (scan_col == nc - COL_CNT_W'(1));
  assign blank_last  = (scan_col == nc - COL_CNT_W'(1));

  assign cmd_row  = ROW_CNT_W'(cmd.payload.read_row);
  assign cmd_col  = COL_CNT_W'(cmd.payload.read_column);
  assign item_row = ROW_CNT_W'(item.read_row);
  assign item_col = COL_CNT_W'(item.read_column);
  assign rd_ok    = (item_row < nr) && (item_col < nc);

  assign cmd.ready   = (state == ST_IDLE);
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == {AW{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (need_nl) state_next = ST_NEWLINE;
        else if (out_free) state_next = ST_IDLE;
      end
      ST_NEWLINE: begin
        if (row_inc >= nr) state_next = (nr > ROW_CNT_W'(1)) ? ST_COPY : ST_DECIDE;
        else state_next = ST_FINISH;
      end
      ST_COPY: begin
        if (copy_last) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (row_dec < nr) state_next = ST_BLANK;
        else state_next = (nr > ROW_CNT_W'(1)) ? ST_COPY : ST_DECIDE;
      end
      ST_BLANK: begin
        if (blank_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cur_row_next     = cur_row;
    cur_col_next     = cur_col;
    scan_row_next    = scan_row;
    scan_col_next    = scan_col;
    cp_wr_valid_next = 1'b0;
    cp_wr_addr_next  = cp_wr_addr;
    rsp_valid_next   = rsp_valid && !rsp.ready;
    rsp_data_next    = rsp_data;
    ram_we           = 1'b0;
    ram_waddr        = {cur_row[ROW_AW-1:0], cur_col[COL_AW-1:0]};
    ram_wdata        = item.character;
    ram_raddr        = {item_row[ROW_AW-1:0], item_col[COL_AW-1:0]};
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = CH_SPACE;
      end
      ST_IDLE: begin
        ram_raddr = {cmd_row[ROW_AW-1:0], cmd_col[COL_AW-1:0]};
      end
      ST_EXEC: begin
        if (!need_nl && out_free) begin
          if (is_put) begin
            if (item.character == CH_RETURN) begin
              cur_col_next = '0;
            end else begin
              ram_we = (cur_row < ROW_CNT_W'(MAX_ROWS)) &&
                       (cur_col < COL_CNT_W'(MAX_COLUMNS));
              cur_col_next = cur_col + COL_CNT_W'(1);
            end
          end
          rsp_valid_next                  = 1'b1;
          rsp_data_next.cursor_row_out    = cur_row_next[5:0];
          rsp_data_next.cursor_column_out = cur_col_next[7:0];
          rsp_data_next.read_char         = (!is_put && rd_ok) ? ram_rdata : 8'd0;
          rsp_data_next.read_valid        = !is_put && rd_ok;
        end
      end
      ST_NEWLINE: begin
        cur_col_next  = '0;
        cur_row_next  = row_inc;
        scan_row_next = ROW_CNT_W'(1);
        scan_col_next = '0;
      end
      ST_COPY: begin
        ram_raddr        = {scan_row[ROW_AW-1:0], scan_col[COL_AW-1:0]};
        cp_wr_valid_next = 1'b1;
        cp_wr_addr_next  = {scan_row_m1[ROW_AW-1:0], scan_col[COL_AW-1:0]};
        if (scan_col == nc - COL_CNT_W'(1)) begin
          scan_col_next = '0;
          scan_row_next = scan_row + ROW_CNT_W'(1);
        end else begin
          scan_col_next = scan_col + COL_CNT_W'(1);
        end
      end
      ST_DECIDE: begin
        cur_row_next  = row_dec;
        scan_row_next = ROW_CNT_W'(1);
        scan_col_next = '0;
      end
      ST_BLANK: begin
        ram_we        = 1'b1;
        ram_waddr     = {cur_row[ROW_AW-1:0], scan_col[COL_AW-1:0]};
        ram_wdata     = CH_SPACE;
        scan_col_next = scan_col + COL_CNT_W'(1);
      end
      ST_FINISH: begin
        if (out_free) begin
          if (ordinary) begin
            ram_we = (cur_row < ROW_CNT_W'(MAX_ROWS)) &&
                     (cur_col < COL_CNT_W'(MAX_COLUMNS));
            cur_col_next = cur_col + COL_CNT_W'(1);
          end
          rsp_valid_next                  = 1'b1;
          rsp_data_next.cursor_row_out    = cur_row_next[5:0];
          rsp_data_next.cursor_column_out = cur_col_next[7:0];
          rsp_data_next.read_char         = 8'd0;
          rsp_data_next.read_valid        = 1'b0;
        end
      end
      default: begin
      end
    endcase
    // copy write follows its read in the next cycle
    if (cp_wr_valid) begin
      ram_we    = 1'b1;
      ram_waddr = cp_wr_addr;
      ram_wdata = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      columns     <= RESET_COLUMNS;
      rows        <= RESET_ROWS;
      cur_row     <= '0;
      cur_col     <= '0;
      clr_addr    <= '0;
      cp_wr_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cur_row     <= cur_row_next;
      cur_col     <= cur_col_next;
      cp_wr_valid <= cp_wr_valid_next;
      rsp_valid   <= rsp_valid_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COLUMNS: columns <= cfg_data;
          REG_ROWS:    rows    <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) item <= cmd.payload;
    scan_row   <= scan_row_next;
    scan_col   <= scan_col_next;
    cp_wr_addr <= cp_wr_addr_next;
    rsp_data   <= rsp_data_next;
  end

  tcw_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- rtl/tcw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/sv/tcw_console_checker.sv -----
// Result checker for the text console writer: follows the command, result and register ports,
// keeps its own screen, cursor and sizes, and compares each result with the oldest prediction.
// Depends on tcw_pkg and the tcw_cmd_if / tcw_rsp_if interfaces.
module tcw_console_checker import tcw_pkg::*; #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 64
) (
  input  logic       clk,
  input  logic       rst,
  tcw_cmd_if         cmd,
  tcw_rsp_if         rsp,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  screen [SCREEN_ROWS][SCREEN_COLUMNS];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0]  columns_reg;
  logic [6:0]  rows_reg;
  rsp_t        awaited_reports [$];

  function automatic int unsigned columns_in_use();
    if (columns_reg == 0) return 1;
    if (columns_reg > SCREEN_COLUMNS) return SCREEN_COLUMNS;
    return columns_reg;
  endfunction

  function automatic int unsigned rows_in_use();
    if (rows_reg == 0) return 1;
    if (rows_reg > SCREEN_ROWS) return SCREEN_ROWS;
    return rows_reg;
  endfunction

  // one scroll per surplus row; only the last one blanks the bottom row
  function automatic void line_feed();
    int unsigned nr;
    int unsigned nc;
    nr = rows_in_use();
    nc = columns_in_use();
    cur_col = 0;
    cur_row++;
    while (cur_row >= nr) begin
      for (int unsigned r = 1; r < nr; r++)
        for (int unsigned c = 0; c < nc; c++) screen[r-1][c] = screen[r][c];
      cur_row--;
      if (cur_row < nr)
        for (int unsigned c = 0; c < nc; c++) screen[cur_row][c] = CH_SPACE;
    end
  endfunction

  function automatic rsp_t console_step(cmd_t item);
    rsp_t report;
    report = '0;
    if (item.operation == OP_PUT) begin
      if (item.character == CH_NEWLINE) begin
        line_feed();
      end else if (item.character == CH_RETURN) begin
        cur_col = 0;
      end else begin
        if (cur_col >= columns_in_use()) line_feed();
        if (cur_row < SCREEN_ROWS && cur_col < SCREEN_COLUMNS)
          screen[cur_row][cur_col] = item.character;
        cur_col++;
      end
    end else if (item.read_row < rows_in_use() && item.read_column < columns_in_use()) begin
      report.read_char  = screen[item.read_row][item.read_column];
      report.read_valid = 1'b1;
    end
    report.cursor_row_out    = cur_row[5:0];
    report.cursor_column_out = cur_col[7:0];
    return report;
  endfunction

  always @(posedge clk) begin : monitor
    rsp_t got;
    rsp_t want;
    if (rst) begin
      for (int r = 0; r < SCREEN_ROWS; r++)
        for (int c = 0; c < SCREEN_COLUMNS; c++) screen[r][c] = CH_SPACE;
      cur_row = 0;
      cur_col = 0;
      columns_reg = RESET_COLUMNS;
      rows_reg = RESET_ROWS;
      awaited_reports.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_COLUMNS) columns_reg = cfg_data;
        else rows_reg = cfg_data[6:0];
      end
      if (rsp.valid && rsp.ready) begin
        got = rsp.payload;
        if (awaited_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: row %0d col %0d char %02h valid %0b",
                     got.cursor_row_out, got.cursor_column_out, got.read_char,
                     got.read_valid);
        end else begin
          want = awaited_reports.pop_front();
          if (got.cursor_row_out !== want.cursor_row_out ||
              got.cursor_column_out !== want.cursor_column_out ||
              got.read_char !== want.read_char ||
              got.read_valid !== want.read_valid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected row %0d col %0d char %02h valid %0b, %s",
                       want.cursor_row_out, want.cursor_column_out, want.read_char,
                       want.read_valid,
                       $sformatf("got row %0d col %0d char %02h valid %0b",
                                 got.cursor_row_out, got.cursor_column_out,
                                 got.read_char, got.read_valid));
          end
        end
      end
      if (cmd.valid && cmd.ready) awaited_reports.push_back(console_step(cmd.payload));
    end
    outstanding <= awaited_reports.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the text console writer testbench: clock, reset, command and register stimulus,
// result back-pressure, watchdog and verdict. Checking is done by tcw_console_checker.
// Depends on tcw_pkg, tcw_cmd_if, tcw_rsp_if, text_console_writer and tcw_console_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int SCREEN_COLUMNS = 128;
  localparam int SCREEN_ROWS    = 64;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 50;
  localparam int SETTLE_CYCLES  = 100;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;
  int         mismatches;
  int         outstanding;
  logic       steady = 1'b0;
  int         cols_in_use = RESET_COLUMNS;
  int         rows_in_use = RESET_ROWS;

  tcw_cmd_if cmd ();
  tcw_rsp_if rsp ();

  text_console_writer #(
    .MAX_COLUMNS(SCREEN_COLUMNS),
    .MAX_ROWS(SCREEN_ROWS)
  ) i_dut (
    .clk, .rst, .cmd(cmd), .rsp(rsp), .cfg_we, .cfg_index, .cfg_data
  );

  tcw_console_checker #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) i_checker (
    .clk, .rst, .cmd(cmd), .rsp(rsp), .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .outstanding
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic cmd_t put_item(logic [7:0] ch);
    cmd_t item;
    item.operation   = OP_PUT;
    item.character   = ch;
    item.read_row    = 6'($urandom_range(0, 63));
    item.read_column = 7'($urandom_range(0, 127));
    return item;
  endfunction

  function automatic cmd_t read_item(int r, int c);
    cmd_t item;
    item.operation   = OP_READ;
    item.character   = 8'($urandom_range(0, 255));
    item.read_row    = 6'(r);
    item.read_column = 7'(c);
    return item;
  endfunction

  function automatic cmd_t random_item();
    cmd_t item;
    int unsigned pick;
    item = put_item(8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      item.operation = OP_READ;
      if (pick < 24) begin
        item.read_row    = 6'($urandom_range(0, rows_in_use - 1));
        item.read_column = 7'($urandom_range(0, cols_in_use - 1));
      end
    end else if (pick < 40) begin
      item.character = CH_NEWLINE;
    end else if (pick < 46) begin
      item.character = CH_RETURN;
    end else if (pick < 80) begin
      item.character = 8'($urandom_range(8'h21, 8'h7E));
    end
    return item;
  endfunction

  task automatic send(input cmd_t item);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.payload <= item;
    cmd.valid <= 1'b1;
    do @(posedge clk); while (!(cmd.valid && cmd.ready));
    @(negedge clk);
  endtask

  task automatic end_batch();
    cmd.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic set_sizes(input logic [7:0] col_value, input logic [6:0] row_value);
    cfg_we <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data <= col_value;
    @(negedge clk);
    cfg_index <= REG_ROWS;
    cfg_data <= {1'b0, row_value};
    @(negedge clk);
    cfg_we <= 1'b0;
    cols_in_use = (col_value == 0) ? 1 : (col_value > SCREEN_COLUMNS) ? SCREEN_COLUMNS
                                                                      : col_value;
    rows_in_use = (row_value == 0) ? 1 : (row_value > SCREEN_ROWS) ? SCREEN_ROWS
                                                                   : row_value;
  endtask

  // result back-pressure
  initial begin : result_sink
    int unsigned gap;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!(rsp.valid && rsp.ready));
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    cmd.valid = 1'b0;
    cmd.payload = '0;
    cfg_we = 1'b0;
    cfg_index = REG_COLUMNS;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset sizes: byte extremes, return, cell bounds
    send(put_item(8'h41));
    send(put_item(8'h00));
    send(put_item(8'hFF));
    send(read_item(0, 0));
    send(read_item(0, 3));
    send(put_item(CH_RETURN));
    send(put_item(8'h42));
    send(read_item(0, 0));
    send(read_item(24, 79));
    send(read_item(25, 0));
    send(read_item(0, 80));
    send(read_item(63, 127));
    send(put_item(CH_NEWLINE));
    end_batch();

    // deferred wrap with scroll
    set_sizes(8'd3, 7'd2);
    send(put_item(8'h61));
    send(put_item(8'h62));
    send(put_item(8'h63));
    send(put_item(8'h64));
    send(read_item(0, 0));
    end_batch();

    // cursor row beyond the row count
    set_sizes(8'd2, 7'd1);
    send(put_item(8'h65));
    send(put_item(CH_NEWLINE));
    send(read_item(1, 1));
    end_batch();

    // zero sizes act as one
    set_sizes(8'd0, 7'd0);
    send(put_item(8'h78));
    send(put_item(8'h79));
    send(read_item(0, 0));
    end_batch();

    // oversized values clamp to the maximum
    set_sizes(8'd255, 7'd127);
    send(read_item(63, 127));
    send(put_item(CH_NEWLINE));
    end_batch();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 1) begin
        set_sizes(8'd1, 7'd1);
      end else if (phase == 2) begin
        set_sizes(8'd128, 7'd64);
      end else if (phase > 2) begin
        case ($urandom_range(0, 9))
          0: set_sizes(8'd0, 7'($urandom_range(0, 4)));
          1: set_sizes(8'($urandom_range(129, 255)), 7'($urandom_range(1, 3)));
          2: set_sizes(8'($urandom_range(1, 4)), 7'($urandom_range(65, 127)));
          default: set_sizes(8'($urandom_range(1, 12)), 7'($urandom_range(1, 6)));
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 23) == 0) steady = !steady;
        send(random_item());
      end
      end_batch();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
